[design/pff_pkg.sv]
// Shared types and constants for the proximity flood fill unit.
// Used by every module of the block; depends on nothing.
package pff_pkg;

	localparam int PFF_MAX_POINTS = 64;
	localparam int PFF_COORD_BITS = 16;

	localparam int IDX_W   = 6;
	localparam int POS_W   = 16;
	localparam int COLOR_W = 3;
	localparam int CNT_W   = 7;
	localparam int DIST_W  = 33;

	localparam logic [CNT_W-1:0]  PC_RESET  = 7'd64;
	localparam logic [DIST_W-1:0] THR_RESET = '0;

	typedef enum logic {
		ACT_LOAD = 1'b0,
		ACT_FILL = 1'b1
	} pff_act_t;

	typedef enum logic [0:0] {
		CFG_POINT_COUNT      = 1'b0,
		CFG_NEIGHBOR_DIST_SQ = 1'b1
	} pff_cfg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHK,
		S_DEQ,
		S_CUR,
		S_ORG,
		S_SCAN,
		S_DRAIN,
		S_EMIT
	} pff_state_t;

	typedef struct packed {
		pff_act_t                  action;
		logic [IDX_W-1:0]          point_index;
		logic signed [POS_W-1:0]   pos_x;
		logic signed [POS_W-1:0]   pos_y;
		logic [COLOR_W-1:0]        color;
	} pff_cmd_t;

	typedef struct packed {
		logic [IDX_W-1:0] filled_index;
		logic             no_change;
		logic             last;
	} pff_res_t;

	typedef struct packed {
		logic load;
		logic recolor;
	} pff_wr_t;

endpackage

[design/pff_store.sv]
// Point table: x, y and color memories with one write port and one registered read port.
// Depends on pff_pkg.
module pff_store import pff_pkg::*; #(
	parameter int MAX_POINTS = PFF_MAX_POINTS,
	parameter int COORD_BITS = PFF_COORD_BITS,
	localparam int AW = $clog2(MAX_POINTS)
) (
	input  logic                         clk,
	input  pff_wr_t                      wr,
	input  logic [AW-1:0]                wr_addr,
	input  logic signed [COORD_BITS-1:0] wr_x,
	input  logic signed [COORD_BITS-1:0] wr_y,
	input  logic [COLOR_W-1:0]           wr_color,
	input  logic [AW-1:0]                rd_addr,
	output logic signed [COORD_BITS-1:0] rd_x,
	output logic signed [COORD_BITS-1:0] rd_y,
	output logic [COLOR_W-1:0]           rd_color
);

	logic signed [COORD_BITS-1:0] x_mem [MAX_POINTS];
	logic signed [COORD_BITS-1:0] y_mem [MAX_POINTS];
	logic [COLOR_W-1:0]           c_mem [MAX_POINTS];

	always_ff @(posedge clk) begin
		if (wr.load) begin
			x_mem[wr_addr] <= wr_x;
			y_mem[wr_addr] <= wr_y;
		end
		if (wr.load || wr.recolor) begin
			c_mem[wr_addr] <= wr_color;
		end
	end

	always_ff @(posedge clk) begin
		rd_x     <= x_mem[rd_addr];
		rd_y     <= y_mem[rd_addr];
		rd_color <= c_mem[rd_addr];
	end

endmodule

[design/pff_dist.sv]
// Shared squared-distance unit: difference, square, then sum and threshold compare.
// Takes one candidate a cycle; depends on pff_pkg.
module pff_dist import pff_pkg::*; #(
	parameter int MAX_POINTS = PFF_MAX_POINTS,
	parameter int COORD_BITS = PFF_COORD_BITS,
	localparam int AW = $clog2(MAX_POINTS)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [DIST_W-1:0]            thr,
	input  logic signed [COORD_BITS-1:0] org_x,
	input  logic signed [COORD_BITS-1:0] org_y,
	input  logic                         in_v,
	input  logic                         in_ok,
	input  logic [AW-1:0]                in_tag,
	input  logic signed [COORD_BITS-1:0] in_x,
	input  logic signed [COORD_BITS-1:0] in_y,
	output logic                         hit,
	output logic [AW-1:0]                hit_tag,
	output logic                         pend
);

	localparam int SQW  = 2 * COORD_BITS;
	localparam int CMPW = (SQW + 1 > DIST_W) ? SQW + 1 : DIST_W;

	logic signed [COORD_BITS:0] dx, dy;
	logic [COORD_BITS-1:0]      ax, ay;
	logic [COORD_BITS-1:0]      ax_s1, ay_s1;
	logic [AW-1:0]              tag_s1, tag_s2;
	logic                       v_s1, v_s2;
	logic [SQW-1:0]             sqx, sqy;
	logic [SQW-1:0]             sqx_s2, sqy_s2;
	logic [CMPW-1:0]            sum;

	assign dx = $signed({org_x[COORD_BITS-1], org_x}) - $signed({in_x[COORD_BITS-1], in_x});
	assign dy = $signed({org_y[COORD_BITS-1], org_y}) - $signed({in_y[COORD_BITS-1], in_y});
	assign ax = dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
	assign ay = dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);

	assign sqx = SQW'(ax_s1) * SQW'(ax_s1);
	assign sqy = SQW'(ay_s1) * SQW'(ay_s1);

	assign sum = CMPW'(sqx_s2) + CMPW'(sqy_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_v && in_ok;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		ax_s1  <= ax;
		ay_s1  <= ay;
		tag_s1 <= in_tag;
		sqx_s2 <= sqx;
		sqy_s2 <= sqy;
		tag_s2 <= tag_s1;
	end

	assign hit     = v_s2 && (sum <= CMPW'(thr));
	assign hit_tag = tag_s2;
	assign pend    = v_s1 || v_s2;

endmodule

[design/pff_ctrl.sv]
// Fill sequencer: command decode, walk queue, visited marks and result register.
// Depends on pff_pkg; drives pff_store and pff_dist.
module pff_ctrl import pff_pkg::*; #(
	parameter int MAX_POINTS = PFF_MAX_POINTS,
	parameter int COORD_BITS = PFF_COORD_BITS,
	localparam int AW = $clog2(MAX_POINTS),
	localparam int CW = $clog2(MAX_POINTS + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  pff_cmd_t                     cmd,
	input  logic [CW-1:0]                n_eff,
	output pff_wr_t                      wr,
	output logic [AW-1:0]                wr_addr,
	output logic [COLOR_W-1:0]           wr_color,
	output logic [AW-1:0]                rd_addr,
	input  logic signed [COORD_BITS-1:0] rd_x,
	input  logic signed [COORD_BITS-1:0] rd_y,
	input  logic [COLOR_W-1:0]           rd_color,
	output logic signed [COORD_BITS-1:0] org_x,
	output logic signed [COORD_BITS-1:0] org_y,
	output logic                         dist_v,
	output logic                         dist_ok,
	output logic [AW-1:0]                dist_tag,
	input  logic                         dist_hit,
	input  logic [AW-1:0]                dist_hit_tag,
	input  logic                         dist_pend,
	output logic                         res_valid,
	output pff_res_t                     res
);

	localparam int IW = (CW > IDX_W) ? CW : IDX_W;

	pff_state_t state_q, state_d;

	logic [AW-1:0]          idx_q, cur_q, rd_tag_q, q_rd_q;
	logic [COLOR_W-1:0]     color_q, start_c_q;
	logic [CW-1:0]          head_q, tail_q, j_q;
	logic [MAX_POINTS-1:0]  visited_q;
	logic                   rd_v_q;
	logic                   res_valid_q;
	pff_res_t               res_q;
	logic signed [COORD_BITS-1:0] org_x_q, org_y_q;
	logic [AW-1:0]          q_mem [MAX_POINTS];

	logic                   acc, fill_ok, load_ok, same_c, q_empty, scan_end;
	logic                   hit_new, q_we, res_set;
	logic [AW-1:0]          q_waddr, q_wdata;
	pff_res_t               res_d;

	assign busy     = (state_q != S_IDLE);
	assign acc      = start && !busy;
	assign fill_ok  = IW'(cmd.point_index) < IW'(n_eff);
	assign load_ok  = IW'(cmd.point_index) < IW'(MAX_POINTS);
	assign same_c   = (rd_color == color_q);
	assign q_empty  = (head_q == tail_q);
	assign scan_end = (j_q == n_eff - CW'(1));
	assign hit_new  = dist_hit && !visited_q[dist_hit_tag];

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc && cmd.action == ACT_FILL && fill_ok) state_d = S_CHK;
			end
			S_CHK:   state_d = same_c ? S_IDLE : S_DEQ;
			S_DEQ:   state_d = S_CUR;
			S_CUR:   state_d = S_ORG;
			S_ORG:   state_d = S_SCAN;
			S_SCAN: begin
				if (scan_end) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (!rd_v_q && !dist_pend) state_d = S_EMIT;
			end
			S_EMIT:  state_d = q_empty ? S_IDLE : S_DEQ;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		rd_addr    = j_q[AW-1:0];
		wr         = '0;
		wr_addr    = AW'(cmd.point_index);
		wr_color   = cmd.color;
		q_we       = 1'b0;
		q_waddr    = tail_q[AW-1:0];
		q_wdata    = dist_hit_tag;
		res_set    = 1'b0;
		res_d      = '0;
		case (state_q)
			S_IDLE: begin
				rd_addr = AW'(cmd.point_index);
				wr.load = acc && cmd.action == ACT_LOAD && load_ok;
			end
			S_CHK: begin
				if (same_c) begin
					res_set            = 1'b1;
					res_d.filled_index = IDX_W'(idx_q);
					res_d.no_change    = 1'b1;
					res_d.last         = 1'b1;
				end else begin
					q_we    = 1'b1;
					q_waddr = '0;
					q_wdata = idx_q;
				end
			end
			S_CUR: rd_addr = q_rd_q;
			S_SCAN, S_DRAIN: q_we = hit_new;
			S_EMIT: begin
				wr.recolor         = 1'b1;
				wr_addr            = cur_q;
				wr_color           = color_q;
				res_set            = 1'b1;
				res_d.filled_index = IDX_W'(cur_q);
				res_d.last         = q_empty;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			j_q         <= '0;
			visited_q   <= '0;
			rd_v_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_v_q      <= (state_q == S_SCAN);
			res_valid_q <= res_set;
			if (state_q == S_CHK && !same_c) begin
				head_q    <= '0;
				tail_q    <= CW'(1);
				visited_q <= {{(MAX_POINTS-1){1'b0}}, 1'b1} << idx_q;
			end else begin
				if (state_q == S_DEQ) head_q <= head_q + CW'(1);
				if (q_we) begin
					tail_q                  <= tail_q + CW'(1);
					visited_q[dist_hit_tag] <= 1'b1;
				end
			end
			if (state_q == S_ORG) j_q <= '0;
			else if (state_q == S_SCAN) j_q <= j_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			idx_q   <= AW'(cmd.point_index);
			color_q <= cmd.color;
		end
		if (state_q == S_CHK) start_c_q <= rd_color;
		if (state_q == S_CUR) cur_q <= q_rd_q;
		if (state_q == S_ORG) begin
			org_x_q <= rd_x;
			org_y_q <= rd_y;
		end
		rd_tag_q <= j_q[AW-1:0];
		if (res_set) res_q <= res_d;
	end

	always_ff @(posedge clk) begin
		if (q_we) q_mem[q_waddr] <= q_wdata;
		q_rd_q <= q_mem[head_q[AW-1:0]];
	end

	assign org_x     = org_x_q;
	assign org_y     = org_y_q;
	assign dist_v    = rd_v_q;
	assign dist_ok   = (rd_color == start_c_q);
	assign dist_tag  = rd_tag_q;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> ($past(state_q) == S_CHK || $past(state_q) == S_EMIT))
		else $error("result strobe without a result state");

	a_tail_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE && state_q != S_CHK) |-> (tail_q <= n_eff))
		else $error("walk queue grew past the point count");

	a_deq_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DEQ) |-> (head_q < tail_q))
		else $error("dequeue from an empty walk queue");

	a_nochg_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.no_change) |-> res_q.last)
		else $error("no-change result not marked last");

	a_hit_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		dist_hit |-> (state_q == S_SCAN || state_q == S_DRAIN))
		else $error("distance hit outside a scan");

endmodule

[design/proximity_flood_fill_unit.sv]
// A load writes the point table while idle and leaves busy low. A no-change fill gives its
// result from the check state. A walk takes each visited point through the dequeue, current,
// origin, scan, drain and emit states, scanning all n active points as one distance pipeline
// checks one point a cycle through the single read port of the point table; busy throughout.
// Results are one-cycle strobes on res_valid; the receiver cannot stall. Reset clears control
// state and the registers (point_count 64, threshold 0), not the point table or walk queue.
module proximity_flood_fill_unit import pff_pkg::*; #(
	parameter int MAX_POINTS = PFF_MAX_POINTS,
	parameter int COORD_BITS = PFF_COORD_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  pff_cmd_t          cmd,
	output logic              res_valid,
	output pff_res_t          res,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  pff_cfg_t          cfg_index,
	input  logic [DIST_W-1:0] cfg_data
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);

	logic [CNT_W-1:0]  pc_q;
	logic [DIST_W-1:0] thr_q;
	logic [CW-1:0]     n_eff;

	pff_wr_t                      wr;
	logic [AW-1:0]                wr_addr, rd_addr, dist_tag, dist_hit_tag;
	logic [COLOR_W-1:0]           wr_color, rd_color;
	logic signed [COORD_BITS-1:0] wr_x, wr_y, rd_x, rd_y, org_x, org_y;
	logic                         dist_v, dist_ok, dist_hit, dist_pend;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= PC_RESET;
			thr_q <= THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_POINT_COUNT:      pc_q  <= cfg_data[CNT_W-1:0];
				CFG_NEIGHBOR_DIST_SQ: thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (pc_q == '0) n_eff = CW'(1);
		else if (int'(pc_q) > MAX_POINTS) n_eff = CW'(MAX_POINTS);
		else n_eff = CW'(pc_q);
	end

	assign wr_x = COORD_BITS'($unsigned(cmd.pos_x));
	assign wr_y = COORD_BITS'($unsigned(cmd.pos_y));

	pff_ctrl #(
		.MAX_POINTS(MAX_POINTS),
		.COORD_BITS(COORD_BITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.n_eff       (n_eff),
		.wr          (wr),
		.wr_addr     (wr_addr),
		.wr_color    (wr_color),
		.rd_addr     (rd_addr),
		.rd_x        (rd_x),
		.rd_y        (rd_y),
		.rd_color    (rd_color),
		.org_x       (org_x),
		.org_y       (org_y),
		.dist_v      (dist_v),
		.dist_ok     (dist_ok),
		.dist_tag    (dist_tag),
		.dist_hit    (dist_hit),
		.dist_hit_tag(dist_hit_tag),
		.dist_pend   (dist_pend),
		.res_valid   (res_valid),
		.res         (res)
	);

	pff_store #(
		.MAX_POINTS(MAX_POINTS),
		.COORD_BITS(COORD_BITS)
	) u_store (
		.clk     (clk),
		.wr      (wr),
		.wr_addr (wr_addr),
		.wr_x    (wr_x),
		.wr_y    (wr_y),
		.wr_color(wr_color),
		.rd_addr (rd_addr),
		.rd_x    (rd_x),
		.rd_y    (rd_y),
		.rd_color(rd_color)
	);

	pff_dist #(
		.MAX_POINTS(MAX_POINTS),
		.COORD_BITS(COORD_BITS)
	) u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.thr    (thr_q),
		.org_x  (org_x),
		.org_y  (org_y),
		.in_v   (dist_v),
		.in_ok  (dist_ok),
		.in_tag (dist_tag),
		.in_x   (rd_x),
		.in_y   (rd_y),
		.hit    (dist_hit),
		.hit_tag(dist_hit_tag),
		.pend   (dist_pend)
	);

endmodule

[tb/proximity_flood_fill_unit_tb.sv]
// Testbench for proximity_flood_fill_unit: loads points, runs fills, and checks the order of
// recolored points against a breadth-first walk predicted from the point table.
// Depends on pff_pkg and the proximity_flood_fill_unit RTL only.
`timescale 1ns / 1ps

module proximity_flood_fill_unit_tb;
	import pff_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam int PHASES      = 5;
	localparam int PHASE_ITEMS = 13;

	class fill_tracker;
		logic signed [POS_W-1:0] px [PFF_MAX_POINTS];
		logic signed [POS_W-1:0] py [PFF_MAX_POINTS];
		logic [COLOR_W-1:0]      pcol [PFF_MAX_POINTS];
		logic [CNT_W-1:0]        point_count;
		logic [DIST_W-1:0]       dist_limit;
		pff_res_t                visit_q [$];
		int                      bad_visits;
		int                      visits_seen;

		function new();
			point_count = PC_RESET;
			dist_limit  = THR_RESET;
			bad_visits  = 0;
			visits_seen = 0;
		endfunction

		function int pending();
			return visit_q.size();
		endfunction

		function void write_reg(pff_cfg_t idx, logic [DIST_W-1:0] data);
			if (idx == CFG_POINT_COUNT) begin
				point_count = data[CNT_W-1:0];
			end else begin
				dist_limit = data;
			end
		endfunction

		function void note_cmd(pff_cmd_t c);
			int            n;
			int            cur;
			int            head;
			longint        dx;
			longint        dy;
			bit            seen [PFF_MAX_POINTS];
			int            walk [$];
			logic [COLOR_W-1:0] old_color;
			pff_res_t      r;
			if (c.action == ACT_LOAD) begin
				px[c.point_index]   = c.pos_x;
				py[c.point_index]   = c.pos_y;
				pcol[c.point_index] = c.color;
				return;
			end
			n = (point_count == 0) ? 1 : (point_count > PFF_MAX_POINTS) ? PFF_MAX_POINTS :
				int'(point_count);
			if (c.point_index >= n)
				return;
			old_color = pcol[c.point_index];
			if (old_color == c.color) begin
				r.filled_index = c.point_index;
				r.no_change    = 1'b1;
				r.last         = 1'b1;
				visit_q.push_back(r);
				return;
			end
			foreach (seen[i])
				seen[i] = 1'b0;
			seen[c.point_index] = 1'b1;
			walk.push_back(int'(c.point_index));
			for (head = 0; head < walk.size(); head++) begin
				cur = walk[head];
				for (int j = 0; j < n; j++) begin
					dx = longint'(px[cur]) - longint'(px[j]);
					dy = longint'(py[cur]) - longint'(py[j]);
					if (!seen[j] && dx * dx + dy * dy <= longint'(dist_limit) &&
							pcol[j] == old_color) begin
						seen[j] = 1'b1;
						walk.push_back(j);
					end
				end
				pcol[cur]      = c.color;
				r.filled_index = cur[IDX_W-1:0];
				r.no_change    = 1'b0;
				r.last         = 1'b0;
				visit_q.push_back(r);
			end
			r = visit_q.pop_back();
			r.last = 1'b1;
			visit_q.push_back(r);
		endfunction

		function void check_visit(pff_res_t got);
			pff_res_t want;
			visits_seen++;
			if (visit_q.size() == 0) begin
				bad_visits++;
				if (bad_visits <= 10)
					$display("ERROR result %0d unexpected: idx=%0d no_change=%0b last=%0b",
						visits_seen, got.filled_index, got.no_change, got.last);
				return;
			end
			want = visit_q.pop_front();
			if (got.filled_index !== want.filled_index || got.no_change !== want.no_change ||
					got.last !== want.last) begin
				bad_visits++;
				if (bad_visits <= 10)
					$display("ERROR result %0d: expected idx=%0d no_change=%0b last=%0b, got idx=%0d no_change=%0b last=%0b",
						visits_seen, want.filled_index, want.no_change, want.last,
						got.filled_index, got.no_change, got.last);
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	pff_cmd_t          cmd;
	logic              res_valid;
	pff_res_t          res;
	logic              cfg_valid;
	logic              cfg_ready;
	pff_cfg_t          cfg_index;
	logic [DIST_W-1:0] cfg_data;

	fill_tracker tracker;
	int          stall_cycles = 0;
	int          idle_pct;
	int          loaded_upto;

	proximity_flood_fill_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid)
				tracker.check_visit(res);
			if (start && !busy)
				tracker.note_cmd(cmd);
			if (cfg_valid && cfg_ready)
				tracker.write_reg(cfg_index, cfg_data);
			if (res_valid || (start && !busy) || (cfg_valid && cfg_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	function automatic pff_cmd_t load_cmd(int idx, logic signed [POS_W-1:0] x,
			logic signed [POS_W-1:0] y, int color);
		pff_cmd_t c;
		c.action      = ACT_LOAD;
		c.point_index = IDX_W'(idx);
		c.pos_x       = x;
		c.pos_y       = y;
		c.color       = COLOR_W'(color);
		return c;
	endfunction

	function automatic pff_cmd_t fill_cmd(int idx, int color);
		pff_cmd_t c;
		c.action      = ACT_FILL;
		c.point_index = IDX_W'(idx);
		c.pos_x       = POS_W'($urandom);
		c.pos_y       = POS_W'($urandom);
		c.color       = COLOR_W'(color);
		return c;
	endfunction

	function automatic pff_cmd_t random_point(int idx);
		pff_cmd_t c;
		c = load_cmd(idx, POS_W'($urandom), POS_W'($urandom), 0);
		if ($urandom_range(7) != 0) begin
			c.pos_x = POS_W'($urandom_range(2047)) - POS_W'(1024);
			c.pos_y = POS_W'($urandom_range(2047)) - POS_W'(1024);
		end
		c.color = ($urandom_range(7) == 0) ? COLOR_W'($urandom_range(7)) :
			COLOR_W'($urandom_range(1));
		return c;
	endfunction

	function automatic pff_cmd_t random_cmd(int n_eff);
		int pick;
		int color;
		pick  = $urandom_range(99);
		color = ($urandom_range(3) == 0) ? $urandom_range(7) : $urandom_range(1);
		if (pick < 35)
			return random_point(($urandom_range(3) == 0) ? $urandom_range(63) :
				$urandom_range(n_eff - 1));
		if (pick < 40 && n_eff < PFF_MAX_POINTS)
			return fill_cmd($urandom_range(63, n_eff), color);
		return fill_cmd($urandom_range(n_eff - 1), color);
	endfunction

	task automatic send_cmd(pff_cmd_t c);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < idle_pct);
		end
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic write_cfg(pff_cfg_t idx, logic [DIST_W-1:0] data);
		start <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int                phase_count [PHASES] = '{8, 16, 127, 12, 64};
		longint            phase_thr [PHASES]   = '{65536, 600000, 2500000, 64'h1_FFFF_FFFF, 0};
		int                phase_idle [PHASES]  = '{0, 80, 9, 0, 80};
		int                n_eff;
		logic [DIST_W-1:0] thr;
		tracker      = new();
		idle_pct     = 0;
		arst_n       = 1'b0;
		start        = 1'b0;
		cmd          = '0;
		cfg_valid    = 1'b0;
		cfg_index    = CFG_POINT_COUNT;
		cfg_data     = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		write_cfg(CFG_POINT_COUNT, 4);
		send_cmd(load_cmd(0, 16'sh7FFF, 16'sh8000, 7));
		send_cmd(load_cmd(1, 16'sh7FFF, 16'sh8000, 7));
		send_cmd(load_cmd(2, 16'sh8000, 16'sh7FFF, 7));
		send_cmd(load_cmd(3, 16'sh0000, 16'sh0000, 0));
		send_cmd(fill_cmd(0, 7));
		send_cmd(fill_cmd(0, 5));
		send_cmd(fill_cmd(63, 1));
		send_cmd(fill_cmd(4, 1));
		send_cmd(fill_cmd(2, 5));
		write_cfg(CFG_NEIGHBOR_DIST_SQ, 33'h1_FFFF_FFFF);
		send_cmd(fill_cmd(0, 2));
		write_cfg(CFG_NEIGHBOR_DIST_SQ, 33'd8589672449);
		send_cmd(fill_cmd(1, 3));
		send_cmd(fill_cmd(3, 0));
		send_cmd(fill_cmd(3, 4));
		write_cfg(CFG_POINT_COUNT, 0);
		send_cmd(fill_cmd(0, 6));
		send_cmd(fill_cmd(1, 6));
		loaded_upto = 4;

		for (int p = 0; p < PHASES; p++) begin
			thr = (p == PHASES - 1) ? DIST_W'($urandom_range(4000000)) :
				phase_thr[p][DIST_W-1:0];
			write_cfg(CFG_POINT_COUNT, DIST_W'(phase_count[p]));
			write_cfg(CFG_NEIGHBOR_DIST_SQ, thr);
			n_eff = (phase_count[p] > PFF_MAX_POINTS) ? PFF_MAX_POINTS : phase_count[p];
			idle_pct = phase_idle[p];
			while (loaded_upto < n_eff) begin
				send_cmd(random_point(loaded_upto));
				loaded_upto++;
			end
			repeat (PHASE_ITEMS)
				send_cmd(random_cmd(n_eff));
		end

		start <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (tracker.bad_visits == 0 && tracker.pending() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
